// ===== rtl/core/cmwc_pkg.sv =====
// Shared types and constants for the CMWC4096 generator.
// No dependencies; every other file of the block but cmwc_ram imports this package.

package cmwc_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BITS_W  = 7;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = WORD_W + MULT_W;
  localparam int unsigned SUM_W   = PROD_W + 1;

  localparam logic [MULT_W-1:0] CMWC_MULT = 15'd18782;
  localparam logic [WORD_W-1:0] CMWC_BASE = 32'hFFFF_FFFE;

  typedef enum logic [OP_W-1:0] {
    OP_GENERATE   = 2'd0,
    OP_LOAD_WORD  = 2'd1,
    OP_LOAD_CARRY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic gen_start;
    logic load_word;
    logic load_carry;
    logic mul_en;
    logic add_en;
    logic fin_en;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/cmwc_in_if.sv =====
// Input channel of the CMWC4096 generator: valid/ready plus one command item.
// Depends on cmwc_pkg for field widths.

interface cmwc_in_if;
  import cmwc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [IDX_W-1:0]    table_index;
  logic [WORD_W-1:0]   load_value;
  logic [BITS_W-1:0]   bits_wanted;

  modport source (output valid, operation, table_index, load_value, bits_wanted,
                  input ready);
  modport sink   (input valid, operation, table_index, load_value, bits_wanted,
                  output ready);
endinterface

// ===== rtl/core/cmwc_out_if.sv =====
// Result channel of the CMWC4096 generator: valid/ready plus one random word.
// Depends on cmwc_pkg for the word width.

interface cmwc_out_if;
  import cmwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

// ===== rtl/core/cmwc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.

module cmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cmwc_ctrl.sv =====
// Controller state machine of the CMWC4096 generator.
// Depends on cmwc_pkg; drives cmd_t into cmwc_dp and reads its status_t.

module cmwc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cmwc_pkg::OP_W-1:0]     in_operation,
  output logic                          in_ready,
  input  cmwc_pkg::status_t             status,
  output cmwc_pkg::cmd_t                cmd
);
  import cmwc_pkg::*;

  state_t state_r, state_nxt;
  logic   in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          unique case (op_t'(in_operation))
            OP_GENERATE: begin
              cmd.gen_start = 1'b1;
              state_nxt     = ST_MUL;
            end
            OP_LOAD_WORD:  cmd.load_word  = 1'b1;
            OP_LOAD_CARRY: cmd.load_carry = 1'b1;
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the new word
        if (status.out_free) begin
          cmd.fin_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/cmwc_dp.sv =====
// Datapath of the CMWC4096 generator: lag table, carry, pointer, multiply-add,
// output register. Depends on cmwc_pkg and cmwc_ram; controlled by cmwc_ctrl.

module cmwc_dp #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cmwc_pkg::cmd_t                  cmd,
  output cmwc_pkg::status_t               status,
  input  logic [cmwc_pkg::IDX_W-1:0]      in_table_index,
  input  logic [cmwc_pkg::WORD_W-1:0]     in_load_value,
  input  logic [cmwc_pkg::BITS_W-1:0]     in_bits_wanted,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [cmwc_pkg::WORD_W-1:0]     out_random_value
);
  import cmwc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(TABLE_DEPTH - 1);

  logic [WORD_W-1:0] carry_r, carry_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt, ptr_step;
  logic [BITS_W-1:0] bits_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  t_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  logic              idx_ok;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [SUM_W-WORD_W-1:0] cy;
  logic [WORD_W:0]   sum_x;
  logic              ovf;
  logic [WORD_W-1:0] x_fix, new_word, keep_mask;

  assign ptr_step = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
  assign idx_ok   = ({1'b0, in_table_index} < (IDX_W + 1)'(TABLE_DEPTH));

  // end-around correction of the 48-bit sum
  assign cy        = t_r[SUM_W-1:WORD_W];
  assign sum_x     = {1'b0, t_r[WORD_W-1:0]} + (WORD_W + 1)'(cy);
  assign ovf       = sum_x[WORD_W];
  assign x_fix     = sum_x[WORD_W-1:0] + WORD_W'(ovf);
  assign carry_nxt = WORD_W'(cy) + WORD_W'(ovf);
  assign new_word  = CMWC_BASE - x_fix;
  assign keep_mask = (bits_r >= BITS_W'(WORD_W)) ? '1
                   : ~({WORD_W{1'b1}} << bits_r[$clog2(WORD_W)-1:0]);

  assign ram_re    = cmd.gen_start;
  assign ram_we    = cmd.fin_en || (cmd.load_word && idx_ok);
  assign ram_wdata = cmd.fin_en ? new_word : in_load_value;
  assign ptr_nxt   = ptr_step;

  always_comb begin
    if (cmd.fin_en) begin
      ram_addr = ptr_r;
    end else if (cmd.load_word) begin
      ram_addr = in_table_index[AW-1:0];
    end else begin
      ram_addr = ptr_nxt;
    end
  end

  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r     <= '0;
      ptr_r       <= PTR_LAST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_carry) begin
        carry_r <= in_load_value;
        ptr_r   <= PTR_LAST;
      end else if (cmd.gen_start) begin
        ptr_r <= ptr_nxt;
      end else if (cmd.fin_en) begin
        carry_r <= carry_nxt;
      end
      if (cmd.fin_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_start) begin
      bits_r <= in_bits_wanted;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(ram_rdata) * PROD_W'(CMWC_MULT);
    end
    if (cmd.add_en) begin
      t_r <= SUM_W'(prod_r) + SUM_W'(carry_r);
    end
    if (cmd.fin_en) begin
      out_data_r <= new_word & keep_mask;
    end
  end

  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

endmodule

// ===== rtl/core/cmwc4096_random_generator.sv =====
// CMWC4096 random word generator, top level.
// Depends on cmwc_pkg, cmwc_in_if, cmwc_out_if, cmwc_ctrl, cmwc_dp.
//
// Usage:
//   in_ch  carries one command per transfer: generate, load table word or
//          load carry (which also rewinds the pointer so entry 0 is next).
//   out_ch carries one masked random word per generate command; loads and
//          the unused operation code give no result.
//   Load table word and load carry leave in_ch.ready high.
//   A generate command holds in_ch.ready low until its steps are done: table read,
//   the 32x15 multiply, the 48-bit add with the carry, then correction and
//   write-back. The word reaches out_ch through the table's read register,
//   prod_r, t_r and the output register.
//   A new command is not taken until the running generate has written back.
//   The output register frees the input side: new commands are taken while a
//   word waits on out_ch. If the receiver stalls, the next generate holds in
//   its last step until the output register is taken.
//   Reset (rst_n low, synchronous) clears the carry, sets the pointer to the
//   last entry and empties the output. The table is not cleared: every entry
//   must be loaded before a generate reaches it.

module cmwc4096_random_generator #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input logic        clk,
  input logic        rst_n,
  cmwc_in_if.sink    in_ch,
  cmwc_out_if.source out_ch
);
  import cmwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  cmwc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .status       (status),
    .cmd          (cmd)
  );

  cmwc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_table_index   (in_ch.table_index),
    .in_load_value    (in_ch.load_value),
    .in_bits_wanted   (in_ch.bits_wanted),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_random_value (out_ch.random_value)
  );

endmodule

// ===== rtl/core/cmwc_checker.sv =====
// Port-level checks for the CMWC4096 generator, bound to the top level.
// Depends on cmwc_pkg for widths and operation codes.

module cmwc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [cmwc_pkg::OP_W-1:0]   in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmwc_pkg::WORD_W-1:0] out_random_value
);
  import cmwc_pkg::*;

  logic gen_xfer;
  assign gen_xfer = in_valid && in_ready && (in_operation == OP_GENERATE);

  // a pending word stays put until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a generate keeps in_ready low through the multiply, add and finish steps
  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    gen_xfer |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a generate is in flight");

  // a fresh result only follows an earlier generate transfer
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(gen_xfer, 4))
    else $error("result without a matching generate");

endmodule

bind cmwc4096_random_generator cmwc_checker u_cmwc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_operation     (in_ch.operation),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_random_value (out_ch.random_value)
);
